// ----- rtl/spa_pkg.sv -----
// ============================================================================
// spa_pkg
// Shared types, codes and sizes for the sparse polynomial adder.
// ============================================================================
package spa_pkg;

    localparam int MAX_TERMS = 32;

    localparam int EXP_W  = 16;
    localparam int COEF_W = 32;

    // request codes
    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_MERGE       = 2'd2;

    typedef struct packed {
        logic        [1:0]        mode;
        logic        [EXP_W-1:0]  exponent;
        logic signed [COEF_W-1:0] coefficient;
    } req_item_t;

    typedef struct packed {
        logic        [EXP_W-1:0]  sum_exponent;
        logic signed [COEF_W-1:0] sum_coefficient;
        logic                     last_term;
        logic                     empty_result;
        logic                     overflow_seen;
    } rsp_item_t;

    // one stored term
    typedef struct packed {
        logic        [EXP_W-1:0]  exponent;
        logic signed [COEF_W-1:0] coefficient;
    } term_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start_merge;
        logic emit_empty;
        logic emit_term;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic lists_empty;
        logic out_full;
        logic out_free;
        logic final_term;
    } status_t;

endpackage

// ----- rtl/spa_datapath.sv -----
// ============================================================================
// spa_datapath
// Term memories, list counters, merge indices, saturating adder and result
// register.
// ============================================================================
module spa_datapath #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spa_pkg::req_item_t req_item,
    input  spa_pkg::cmd_t      cmd,
    output spa_pkg::status_t   status,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spa_pkg::rsp_item_t rsp_item
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    spa_pkg::term_t first_mem  [MAX_TERMS];
    spa_pkg::term_t second_mem [MAX_TERMS];

    spa_pkg::term_t first_rd_reg;
    spa_pkg::term_t second_rd_reg;

    logic [CNT_W-1:0] first_cnt_reg, first_cnt_next;
    logic [CNT_W-1:0] second_cnt_reg, second_cnt_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             ovf_reg, ovf_next;
    logic             rsp_valid_reg, rsp_valid_next;
    spa_pkg::rsp_item_t rsp_item_reg, rsp_item_next;

    logic first_full, second_full;
    logic have_first, have_second;
    logic adv_first, adv_second;
    logic [CNT_W-1:0] i_adv, j_adv;
    logic is_last;
    logic [spa_pkg::EXP_W-1:0]         term_exp;
    logic signed [spa_pkg::COEF_W-1:0] term_coef;
    logic signed [spa_pkg::COEF_W:0]   wide_sum;
    logic signed [spa_pkg::COEF_W-1:0] sat_sum;
    spa_pkg::term_t new_term;

    assign first_full  = (first_cnt_reg == CNT_W'(MAX_TERMS));
    assign second_full = (second_cnt_reg == CNT_W'(MAX_TERMS));
    assign new_term    = '{exponent: req_item.exponent, coefficient: req_item.coefficient};

    // term memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && !first_full)
        begin
            first_mem[first_cnt_reg[IDX_W-1:0]] <= new_term;
        end
        if (cmd.load_second && !second_full)
        begin
            second_mem[second_cnt_reg[IDX_W-1:0]] <= new_term;
        end
        first_rd_reg  <= first_mem[i_reg[IDX_W-1:0]];
        second_rd_reg <= second_mem[j_reg[IDX_W-1:0]];
    end

    // saturating Q16.16 add
    always_comb
    begin
        wide_sum = {first_rd_reg.coefficient[spa_pkg::COEF_W-1], first_rd_reg.coefficient}
                 + {second_rd_reg.coefficient[spa_pkg::COEF_W-1], second_rd_reg.coefficient};
        if (wide_sum[spa_pkg::COEF_W] != wide_sum[spa_pkg::COEF_W-1])
        begin
            sat_sum = wide_sum[spa_pkg::COEF_W]
                    ? {1'b1, {(spa_pkg::COEF_W-1){1'b0}}}
                    : {1'b0, {(spa_pkg::COEF_W-1){1'b1}}};
        end
        else
        begin
            sat_sum = wide_sum[spa_pkg::COEF_W-1:0];
        end
    end

    // merge step selection
    always_comb
    begin
        have_first  = (i_reg < first_cnt_reg);
        have_second = (j_reg < second_cnt_reg);
        adv_first   = 1'b0;
        adv_second  = 1'b0;
        term_exp    = second_rd_reg.exponent;
        term_coef   = second_rd_reg.coefficient;
        priority if (have_first && have_second &&
                     first_rd_reg.exponent == second_rd_reg.exponent)
        begin
            adv_first  = 1'b1;
            adv_second = 1'b1;
            term_exp   = first_rd_reg.exponent;
            term_coef  = sat_sum;
        end
        else if (have_first && (!have_second ||
                 first_rd_reg.exponent > second_rd_reg.exponent))
        begin
            adv_first = 1'b1;
            term_exp  = first_rd_reg.exponent;
            term_coef = first_rd_reg.coefficient;
        end
        else
        begin
            adv_second = 1'b1;
        end
        i_adv   = i_reg + CNT_W'(adv_first);
        j_adv   = j_reg + CNT_W'(adv_second);
        is_last = (i_adv >= first_cnt_reg) && (j_adv >= second_cnt_reg);
    end

    always_comb
    begin
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        ovf_next        = ovf_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_item_next   = rsp_item_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.load_first)
        begin
            if (first_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                first_cnt_next = first_cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.load_second)
        begin
            if (second_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                second_cnt_next = second_cnt_reg + CNT_W'(1);
            end
        end

        if (cmd.start_merge)
        begin
            i_next = '0;
            j_next = '0;
        end

        if (cmd.emit_empty)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = '{sum_exponent: '0, sum_coefficient: '0, last_term: 1'b1,
                               empty_result: 1'b1, overflow_seen: ovf_reg};
        end

        if (cmd.emit_term)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = '{sum_exponent: term_exp, sum_coefficient: term_coef,
                               last_term: is_last, empty_result: 1'b0,
                               overflow_seen: ovf_reg};
            if (is_last)
            begin
                first_cnt_next  = '0;
                second_cnt_next = '0;
                i_next          = '0;
                j_next          = '0;
            end
            else
            begin
                i_next = i_adv;
                j_next = j_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            ovf_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            ovf_reg        <= ovf_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign status.lists_empty = (first_cnt_reg == '0) && (second_cnt_reg == '0);
    assign status.out_full    = rsp_valid_reg;
    assign status.out_free    = !rsp_valid_reg || !rsp_stall;
    assign status.final_term  = is_last;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ----- rtl/spa_ctrl.sv -----
// ============================================================================
// spa_ctrl
// Request acceptance and merge sequencing.
// ============================================================================
module spa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_mode,
    output logic             req_stall,
    input  spa_pkg::status_t status,
    output spa_pkg::cmd_t    cmd
);

    spa_pkg::state_t state_reg, state_next;
    logic accept;

    // a merge needs the result register; loads do not
    assign req_stall = (state_reg != spa_pkg::ST_IDLE) ||
                       ((req_mode == spa_pkg::MODE_MERGE) && status.out_full);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                if (accept && (req_mode == spa_pkg::MODE_MERGE) && !status.lists_empty)
                begin
                    state_next = spa_pkg::ST_FETCH;
                end
            end
            spa_pkg::ST_FETCH:
            begin
                state_next = spa_pkg::ST_EMIT;
            end
            spa_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.final_term ? spa_pkg::ST_IDLE : spa_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = spa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            spa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_first  = (req_mode == spa_pkg::MODE_LOAD_FIRST);
                    cmd.load_second = (req_mode == spa_pkg::MODE_LOAD_SECOND);
                    if (req_mode == spa_pkg::MODE_MERGE)
                    begin
                        cmd.emit_empty  = status.lists_empty;
                        cmd.start_merge = !status.lists_empty;
                    end
                end
            end
            spa_pkg::ST_FETCH:
            begin
                cmd = '0;
            end
            spa_pkg::ST_EMIT:
            begin
                cmd.emit_term = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/sparse_polynomial_adder_unit.sv -----
// ============================================================================
// sparse_polynomial_adder_unit
// Adds two sparse polynomials held as descending-exponent term lists.
// ============================================================================
// Usage:
//   Request channel (req_valid / req_stall / req_item) carries one item per
//   handshake: load a term into the first list, load a term into the second
//   list, or merge. Mode 3 is accepted and ignored.
//   A load gives no result. A load into a full list is dropped and sets the
//   sticky overflow flag, reported in every result. A merge streams result
//   items on the response channel (rsp_valid / rsp_stall / rsp_item), one
//   per term, the final one with last_term set. With both lists empty a
//   single item with empty_result set comes out in the cycle after the
//   request. Otherwise each term passes through a fetch state, which does
//   the registered memory read, and an emit state, which does the
//   compare/add and loads the result register, so a term is fetched only
//   after the one before it has been emitted. Both lists are empty after
//   a merge, and the request channel is held until its final term is emitted.
//   While a merge runs req_stall is high. A merge request also waits while
//   the previous result is still held; loads are taken meanwhile.
//   When the receiver stalls, the result register holds its item and the
//   merge pauses. Reset clears the counts, indices, overflow flag and
//   rsp_valid; term memory contents are not cleared and need no clearing.
// ============================================================================
module sparse_polynomial_adder_unit #(
    parameter int MAX_TERMS = spa_pkg::MAX_TERMS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  spa_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spa_pkg::rsp_item_t rsp_item
);

    spa_pkg::cmd_t    cmd;
    spa_pkg::status_t status;

    // sequencing: idle / fetch / emit
    spa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_mode  (req_item.mode),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // storage, merge compare, saturating add, result register
    spa_datapath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

// ----- rtl/spa_checker.sv -----
// ============================================================================
// spa_checker
// Port-level checks for the sparse polynomial adder.
// ============================================================================
module spa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input spa_pkg::req_item_t req_item,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input spa_pkg::rsp_item_t rsp_item
);

    // held result stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("result changed while stalled");

    // an empty merge is a one-item run
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.empty_result |-> rsp_item.last_term)
        else $error("empty result without last_term");

    // overflow is sticky across results
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.overflow_seen |=> !rsp_valid || rsp_item.overflow_seen)
        else $error("overflow flag dropped");

    // a load never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && !rsp_valid &&
        (req_item.mode == spa_pkg::MODE_LOAD_FIRST ||
         req_item.mode == spa_pkg::MODE_LOAD_SECOND) |=> !rsp_valid)
        else $error("result after a load");

endmodule

bind sparse_polynomial_adder_unit spa_checker u_spa_checker (.*);
